### hw/rtl/barometric_sensor_compensation_core_assert.svh
// assertion macros shared by the compensation core rtl
`ifndef BAROMETRIC_SENSOR_COMPENSATION_CORE_ASSERT_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BSC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bsc assertion failed");

// next-cycle implication, disabled during reset
`define BSC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bsc assertion failed");

`endif

### hw/rtl/bsc_pkg.sv
// ---------------------------------------------------------------------------
// bsc_pkg
// constants, register indexes and saturation helpers of the compensation core
// ---------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_AC123 = 3'd0,
    CFG_AC456 = 3'd1,
    CFG_B12   = 3'd2,
    CFG_MCMD  = 3'd3,
    CFG_OSS   = 3'd4
  } bsc_cfg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 48;

  // compensation constants
  localparam logic [31:0] B6_OFFSET = 32'd4000;
  localparam logic [31:0] B4_BIAS   = 32'd32768;
  localparam logic [15:0] B7_SCALE  = 16'd50000;
  localparam logic [31:0] P_C1      = 32'd3038;
  localparam logic [31:0] P_C2      = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] P_C3      = 32'd3791;
  localparam logic [15:0] WORD_ONES = 16'hFFFF;

  // saturate a 32-bit two's complement word to 16 bits
  function automatic logic [15:0] sat16(logic [31:0] v);
    logic [15:0] r;
    if ($signed(v) > 32'sd32767) begin
      r = 16'h7FFF;
    end else if ($signed(v) < -32'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // saturate a 32-bit two's complement word to 20 bits
  function automatic logic [19:0] sat20(logic [31:0] v);
    logic [19:0] r;
    if ($signed(v) > 32'sd524287) begin
      r = 20'h7FFFF;
    end else if ($signed(v) < -32'sd524288) begin
      r = 20'h80000;
    end else begin
      r = v[19:0];
    end
    return r;
  endfunction

  // calibration word that reads as all zeros or all ones
  function automatic logic bad_word(logic [15:0] w);
    return (w == 16'h0000) || (w == WORD_ONES);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/bsc_div_pipe.sv
// ---------------------------------------------------------------------------
// bsc_div_pipe
// pipelined unsigned restoring divider, one quotient bit per stage, with a
// sideband word that travels alongside the operands
// ---------------------------------------------------------------------------
`default_nettype none

module bsc_div_pipe #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 32,
  parameter int unsigned SB_W  = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  input  wire logic [SB_W-1:0]  sb_i,
  output logic                  valid_o,
  output logic [NUM_W-1:0]      quot_o,
  output logic [SB_W-1:0]       sb_o
);

  // per-stage registers: remaining dividend bits shift out as quotient bits shift in
  logic [NUM_W-1:0] nq_q  [NUM_W];
  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];
  logic [SB_W-1:0]  sb_q  [NUM_W];
  logic [NUM_W-1:0] vld_q;

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [NUM_W-1:0] nq_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [SB_W-1:0]  sb_in;
    logic             vld_in;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;

    // stage input select
    if (s == 0) begin : g_first
      assign nq_in  = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
      assign sb_in  = sb_i;
      assign vld_in = valid_i;
    end else begin : g_rest
      assign nq_in  = nq_q[s-1];
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign sb_in  = sb_q[s-1];
      assign vld_in = vld_q[s-1];
    end

    // trial subtract of the shifted remainder
    assign shifted = {rem_in, nq_in[NUM_W-1]};
    assign diff    = shifted - {1'b0, den_in};
    assign ge      = (shifted >= {1'b0, den_in});

    // valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    // payload
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[s]  <= {nq_in[NUM_W-2:0], ge};
        rem_q[s] <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        den_q[s] <= den_in;
        sb_q[s]  <= sb_in;
      end
    end
  end

  assign valid_o = vld_q[NUM_W-1];
  assign quot_o  = nq_q[NUM_W-1];
  assign sb_o    = sb_q[NUM_W-1];

endmodule

`default_nettype wire

### hw/rtl/barometric_sensor_compensation_core.sv
// ---------------------------------------------------------------------------
// barometric_sensor_compensation_core
// integer temperature and pressure compensation from stored calibration
// ---------------------------------------------------------------------------
// usage:
//   calibration words and the oversampling setting are written through the
//   cfg port (write enable, index, data) while no sample is in flight.
//   a sample pair enters on the s_axis channel; one result leaves on the
//   m_axis channel for every sample, in order.
//   path: a result reaches m_axis through the 27-stage and the 32-stage
//   divider pipelines plus nine arithmetic stages.
//   throughput: one sample per cycle unless m_axis stalls.
//   stall: when the receiver holds m_axis_tready low with a result waiting,
//   the whole pipeline freezes and s_axis_tready drops, nothing lost or
//   repeated; the input side may keep transferring while the output register
//   is empty or is being emptied.
//   reset: all valid bits and calibration registers clear; the pipeline is
//   empty and ready in the first cycle after reset is released.
// ---------------------------------------------------------------------------
`default_nettype none

module barometric_sensor_compensation_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration write port
  input  wire logic                         cfg_we_i,
  input  wire logic [bsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bsc_pkg::CfgDataW-1:0] cfg_data_i,
  // sample input
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [39:0]                  s_axis_tdata,  // raw_temp, raw_pressure_word
  // result output
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // temperature_tenths, pressure_pa, pressure_bad, calib_invalid, zero pad
  output logic [39:0]                       m_axis_tdata
);

  import bsc_pkg::*;

  // configuration registers
  logic [47:0] coef_a123_q;
  logic [47:0] coef_a456_q;
  logic [31:0] coef_b12_q;
  logic [31:0] coef_mcmd_q;
  logic [1:0]  oss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a123_q <= '0;
      coef_a456_q <= '0;
      coef_b12_q  <= '0;
      coef_mcmd_q <= '0;
      oss_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_AC123: coef_a123_q <= cfg_data_i;
        CFG_AC456: coef_a456_q <= cfg_data_i;
        CFG_B12:   coef_b12_q  <= cfg_data_i[31:0];
        CFG_MCMD:  coef_mcmd_q <= cfg_data_i[31:0];
        CFG_OSS:   oss_q       <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // coefficient fields; ac1, ac2, ac3, b1, b2 and md sign-extended to 32 bits
  logic [31:0] ac1, ac2, ac3, b1, b2, md;
  logic [15:0] ac4, ac5, ac6, mc;

  assign ac1 = {{16{coef_a123_q[47]}}, coef_a123_q[47:32]};
  assign ac2 = {{16{coef_a123_q[31]}}, coef_a123_q[31:16]};
  assign ac3 = {{16{coef_a123_q[15]}}, coef_a123_q[15:0]};
  assign ac4 = coef_a456_q[47:32];
  assign ac5 = coef_a456_q[31:16];
  assign ac6 = coef_a456_q[15:0];
  assign b1  = {{16{coef_b12_q[31]}}, coef_b12_q[31:16]};
  assign b2  = {{16{coef_b12_q[15]}}, coef_b12_q[15:0]};
  assign mc  = coef_mcmd_q[31:16];
  assign md  = {{16{coef_mcmd_q[15]}}, coef_mcmd_q[15:0]};

  // pipeline advances whenever the output register can take a result
  logic en;
  logic m_valid_q;

  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // stage 0: capture and align
  logic        v0_q;
  logic [15:0] ut0_q;
  logic [18:0] up0_q;
  logic [3:0]  up_sh;

  assign up_sh = 4'd8 - {2'b00, oss_q};

  // stage 1: x1 of the temperature path
  logic        v1_q;
  logic [31:0] x1t_q;
  logic [18:0] up1_q;
  logic [31:0] t_diff;
  logic [31:0] t_prod;

  assign t_diff = {16'h0000, ut0_q} - {16'h0000, ac6};
  assign t_prod = t_diff * {16'h0000, ac5};

  // divider 1 setup: signed (mc * 2048) / (x1 + md) on magnitudes
  logic [31:0] denom;
  logic [31:0] den_mag;
  logic [15:0] mc_mag;
  logic [26:0] num1;
  logic        q_neg;
  logic        den_zero;

  assign denom    = x1t_q + md;
  assign den_mag  = denom[31] ? (32'd0 - denom) : denom;
  assign mc_mag   = mc[15] ? (16'd0 - mc) : mc;
  assign num1     = {mc_mag, 11'd0};
  assign q_neg    = mc[15] ^ denom[31];
  assign den_zero = (denom == '0);

  localparam int unsigned Sb1W = 19 + 32 + 2;

  logic            d1_valid;
  logic [26:0]     d1_quot;
  logic [Sb1W-1:0] d1_sb;

  bsc_div_pipe #(
    .NUM_W (27),
    .DEN_W (32),
    .SB_W  (Sb1W)
  ) u_div_b5 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1_q),
    .num_i   (num1),
    .den_i   (den_mag),
    .sb_i    ({up1_q, x1t_q, q_neg, den_zero}),
    .valid_o (d1_valid),
    .quot_o  (d1_quot),
    .sb_o    (d1_sb)
  );

  // stage 3: b5
  logic        v3_q;
  logic [31:0] b5_q;
  logic [18:0] up3_q;
  logic [31:0] q_mag32;
  logic [31:0] q_signed;
  logic [31:0] d1_x1;

  assign q_mag32  = {5'd0, d1_quot};
  assign q_signed = d1_sb[1] ? (32'd0 - q_mag32) : q_mag32;
  assign d1_x1    = d1_sb[33:2];

  // stage 4: temperature, b6 and its square
  logic        v4_q;
  logic [15:0] t4_q;
  logic [31:0] b6_4_q;
  logic [31:0] b6sq_q;
  logic [18:0] up4_q;
  logic [31:0] t_round;
  logic [31:0] b6;
  logic [31:0] b6_prod;

  assign t_round = b5_q + 32'd8;
  assign b6      = b5_q - B6_OFFSET;
  assign b6_prod = b6 * b6;

  // stage 5: four coefficient products
  logic        v5_q;
  logic [15:0] t5_q;
  logic [18:0] up5_q;
  logic [31:0] pa_q, pb_q, pc_q, pd_q;
  logic [31:0] prod_a, prod_b, prod_c, prod_d;

  assign prod_a = b2 * b6sq_q;
  assign prod_b = ac2 * b6_4_q;
  assign prod_c = ac3 * b6_4_q;
  assign prod_d = b1 * b6sq_q;

  // stage 6: b3 and x3
  logic        v6_q;
  logic [15:0] t6_q;
  logic [18:0] up6_q;
  logic [31:0] b3_q;
  logic [31:0] x3_q;
  logic [31:0] b3_sum;
  logic [31:0] b3_shl;
  logic [31:0] x3_sum;

  assign b3_sum = {ac1[29:0], 2'b00} + pa_q + pb_q;
  assign b3_shl = (b3_sum << oss_q) + 32'd2;
  assign x3_sum = pc_q + pd_q + 32'd2;

  // stage 7: b4 and b7
  logic        v7_q;
  logic [15:0] t7_q;
  logic [31:0] b4_q;
  logic [31:0] b7_q;
  logic [31:0] b4_prod;
  logic [15:0] b7_scale;
  logic [31:0] b7_prod;

  assign b4_prod  = {16'h0000, ac4} * (x3_q + B4_BIAS);
  assign b7_scale = B7_SCALE >> oss_q;
  assign b7_prod  = ({13'd0, up6_q} - b3_q) * {16'h0000, b7_scale};

  // divider 2 setup: doubling before the divide unless b7 is large
  logic [31:0] num2;
  logic        post_dbl;
  logic        p_bad;

  assign post_dbl = b7_q[31];
  assign num2     = post_dbl ? b7_q : {b7_q[30:0], 1'b0};
  assign p_bad    = (b4_q == '0);

  localparam int unsigned Sb2W = 16 + 2;

  logic            d2_valid;
  logic [31:0]     d2_quot;
  logic [Sb2W-1:0] d2_sb;

  bsc_div_pipe #(
    .NUM_W (32),
    .DEN_W (32),
    .SB_W  (Sb2W)
  ) u_div_p (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7_q),
    .num_i   (num2),
    .den_i   (b4_q),
    .sb_i    ({t7_q, p_bad, post_dbl}),
    .valid_o (d2_valid),
    .quot_o  (d2_quot),
    .sb_o    (d2_sb)
  );

  // stage 9: p and the first correction products
  logic        v9_q;
  logic [15:0] t9_q;
  logic        bad9_q;
  logic [31:0] p9_q;
  logic [31:0] xx9_q;
  logic [31:0] x2_9_q;
  logic [31:0] p_raw;
  logic [31:0] p_hi;
  logic [31:0] x2_prod;

  assign p_raw   = d2_sb[0] ? {d2_quot[30:0], 1'b0} : d2_quot;
  assign p_hi    = 32'($signed(p_raw) >>> 8);
  assign x2_prod = P_C2 * p_raw;

  // stage 10: scaled square term
  logic        v10_q;
  logic [15:0] t10_q;
  logic        bad10_q;
  logic [31:0] p10_q;
  logic [31:0] x1_10_q;
  logic [31:0] x2_10_q;
  logic [31:0] x1_prod;

  assign x1_prod = xx9_q * P_C1;

  // output stage: final pressure, saturation and flags
  logic [31:0] p_corr;
  logic [31:0] p_fin;
  logic        cinv;

  assign p_corr = x1_10_q + x2_10_q + P_C3;
  assign p_fin  = p10_q + 32'($signed(p_corr) >>> 4);
  assign cinv   = bad_word(ac1[15:0]) || bad_word(ac2[15:0]) || bad_word(ac3[15:0]) ||
                  bad_word(ac4) || bad_word(ac5) || bad_word(ac6);

  logic [15:0] m_temp_q;
  logic [19:0] m_pres_q;
  logic        m_bad_q;
  logic        m_cinv_q;

  // valid bits of the arithmetic stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q      <= 1'b0;
      v1_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
      v6_q      <= 1'b0;
      v7_q      <= 1'b0;
      v9_q      <= 1'b0;
      v10_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else if (en) begin
      v0_q      <= s_axis_tvalid;
      v1_q      <= v0_q;
      v3_q      <= d1_valid;
      v4_q      <= v3_q;
      v5_q      <= v4_q;
      v6_q      <= v5_q;
      v7_q      <= v6_q;
      v9_q      <= d2_valid;
      v10_q     <= v9_q;
      m_valid_q <= v10_q;
    end
  end

  // payload of the arithmetic stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      ut0_q    <= s_axis_tdata[15:0];
      up0_q    <= 19'(s_axis_tdata[39:16] >> up_sh);

      x1t_q    <= 32'($signed(t_prod) >>> 15);
      up1_q    <= up0_q;

      b5_q     <= d1_sb[0] ? d1_x1 : (d1_x1 + q_signed);
      up3_q    <= d1_sb[52:34];

      t4_q     <= sat16(32'($signed(t_round) >>> 4));
      b6_4_q   <= b6;
      b6sq_q   <= 32'($signed(b6_prod) >>> 12);
      up4_q    <= up3_q;

      t5_q     <= t4_q;
      up5_q    <= up4_q;
      pa_q     <= 32'($signed(prod_a) >>> 11);
      pb_q     <= 32'($signed(prod_b) >>> 11);
      pc_q     <= 32'($signed(prod_c) >>> 13);
      pd_q     <= 32'($signed(prod_d) >>> 16);

      t6_q     <= t5_q;
      up6_q    <= up5_q;
      b3_q     <= 32'($signed(b3_shl) >>> 2);
      x3_q     <= 32'($signed(x3_sum) >>> 2);

      t7_q     <= t6_q;
      b4_q     <= b4_prod >> 15;
      b7_q     <= b7_prod;

      t9_q     <= d2_sb[17:2];
      bad9_q   <= d2_sb[1];
      p9_q     <= p_raw;
      xx9_q    <= p_hi * p_hi;
      x2_9_q   <= 32'($signed(x2_prod) >>> 16);

      t10_q    <= t9_q;
      bad10_q  <= bad9_q;
      p10_q    <= p9_q;
      x1_10_q  <= 32'($signed(x1_prod) >>> 16);
      x2_10_q  <= x2_9_q;

      m_temp_q <= t10_q;
      m_pres_q <= bad10_q ? 20'd0 : sat20(p_fin);
      m_bad_q  <= bad10_q;
      m_cinv_q <= cinv;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, m_cinv_q, m_bad_q, m_pres_q, m_temp_q};

  // checks
  `include "barometric_sensor_compensation_core_assert.svh"

  `BSC_ASSERT_IMP(a_stall_blocks_input, clk_i, rst_ni,
                  m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  `BSC_ASSERT_IMP(a_bad_pressure_zero, clk_i, rst_ni,
                  m_axis_tvalid && m_axis_tdata[36], m_axis_tdata[35:16] == 20'd0)
  `BSC_ASSERT_NXT(a_stall_keeps_result, clk_i, rst_ni,
                  m_valid_q && !m_axis_tready, m_valid_q && $stable(m_pres_q))

endmodule

`default_nettype wire
